[hw/rtl/ffpa_pkg.sv]
package ffpa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HDR_BYTES    = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam int OFF_W        = 16;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  // padded request plus header, and that plus another header
  localparam int NEED_W       = OFF_W + 2;
  localparam int IN_TDATA_W   = 2 * OFF_W;
  localparam int OUT_TDATA_W  = 2 + 3 * OFF_W + 2 * CNT_W;

  localparam logic [OFF_W-1:0] POOL_RESET = OFF_W'(4096);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  typedef struct packed {
    logic             present;
    logic             used;
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic             shift;
    logic             init;
    logic [OFF_W-1:0] pool;
  } chain_ctl_t;

endpackage

[hw/rtl/ffpa_cell.sv]
module ffpa_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ffpa_pkg::chain_ctl_t ctl,
  input  logic                is_first,
  input  ffpa_pkg::entry_t    d_in,
  output ffpa_pkg::entry_t    q
);
  import ffpa_pkg::*;

  entry_t q_r, q_nxt, seed;

  // the first cell holds the single free block after reset or a pool write
  always_comb begin
    seed = '0;
    if (is_first) begin
      seed.present = 1'b1;
      seed.len     = rst_n ? ctl.pool : POOL_RESET;
    end
  end

  always_comb begin
    q_nxt = q_r;
    priority if (ctl.init) begin
      q_nxt = seed;
    end else if (ctl.shift) begin
      q_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= seed;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[hw/rtl/ffpa_ctrl.sv]
module ffpa_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ffpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ffpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [ffpa_pkg::OFF_W-1:0]       cfg_wdata,
  input  ffpa_pkg::entry_t                 tail,
  output ffpa_pkg::entry_t                 head,
  output ffpa_pkg::chain_ctl_t             ctl
);
  import ffpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic mode_r, mode_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [OFF_W-1:0] fs_r, fs_nxt;
  logic fs_ok_r, fs_ok_nxt, null_r, null_nxt;
  logic found_r, found_nxt, empty_r, empty_nxt;
  logic [OFF_W-1:0] hit_start_r, hit_start_nxt, hit_len_r, hit_len_nxt;
  logic p_found_r, p_found_nxt, n_found_r, n_found_nxt, n_free_r, n_free_nxt;
  logic [OFF_W-1:0] n_start_r, n_start_nxt, n_len_r, n_len_nxt;
  logic placed_r, placed_nxt;
  logic [OFF_W-1:0] avail_r, avail_nxt, alloc_r, alloc_nxt;
  logic [CNT_W-1:0] nfree_r, nfree_nxt, nused_r, nused_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [OFF_W-1:0] req, addr;
  logic accept, last, split, nmerge, fit, is_prev;
  logic [OFF_W-1:0] merged_len;
  entry_t rem;
  logic [1:0] status;
  logic [OFF_W-1:0] grant;

  assign req    = in_tdata[OFF_W-1:0];
  assign addr   = in_tdata[2*OFF_W-1:OFF_W];
  assign accept = in_tvalid && in_tready;
  assign last   = (cnt_r == IDX_W'(MAX_BLOCKS - 1));

  assign in_tready = (state_r == S_IDLE);

  assign ctl.shift = (state_r == S_SCAN) || (state_r == S_APPLY);
  assign ctl.init  = cfg_we;
  assign ctl.pool  = cfg_wdata;

  // remainder is split off only when it can hold a header and a cell is empty
  assign split = (mode_r == MODE_ALLOC) && found_r && empty_r &&
                 ({2'b0, hit_len_r} >= need_r + NEED_W'(HDR_BYTES));
  assign rem.present = 1'b1;
  assign rem.used    = 1'b0;
  assign rem.start   = hit_start_r + need_r[OFF_W-1:0];
  assign rem.len     = hit_len_r - need_r[OFF_W-1:0];

  assign nmerge = n_found_r && n_free_r &&
                  ({1'b0, n_start_r} == {1'b0, fs_r} + {1'b0, hit_len_r});
  assign merged_len = hit_len_r + (nmerge ? n_len_r : '0);

  assign fit = tail.present && !tail.used && ({2'b0, tail.len} >= need_r);
  assign is_prev = tail.present && !tail.used &&
                   ({1'b0, tail.start} + {1'b0, tail.len} == {1'b0, fs_r});

  always_comb begin
    if (mode_r == MODE_ALLOC) begin
      status = found_r ? ST_OK : ST_NOFIT;
    end else if (null_r) begin
      status = ST_NULL;
    end else begin
      status = found_r ? ST_OK : ST_UNKNOWN;
    end
    grant = ((mode_r == MODE_ALLOC) && found_r) ? hit_start_r + OFF_W'(HDR_BYTES) : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    need_nxt      = need_r;
    fs_nxt        = fs_r;
    fs_ok_nxt     = fs_ok_r;
    null_nxt      = null_r;
    found_nxt     = found_r;
    empty_nxt     = empty_r;
    hit_start_nxt = hit_start_r;
    hit_len_nxt   = hit_len_r;
    p_found_nxt   = p_found_r;
    n_found_nxt   = n_found_r;
    n_free_nxt    = n_free_r;
    n_start_nxt   = n_start_r;
    n_len_nxt     = n_len_r;
    placed_nxt    = placed_r;
    avail_nxt     = avail_r;
    alloc_nxt     = alloc_r;
    nfree_nxt     = nfree_r;
    nused_nxt     = nused_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    head          = tail;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt    = in_tuser;
          need_nxt    = NEED_W'(((({2'b0, req} + NEED_W'(ALIGN_BYTES - 1)) / ALIGN_BYTES)
                        * ALIGN_BYTES)) + NEED_W'(HDR_BYTES);
          fs_nxt      = addr - OFF_W'(HDR_BYTES);
          fs_ok_nxt   = (addr >= OFF_W'(HDR_BYTES));
          null_nxt    = (addr == '0);
          found_nxt   = 1'b0;
          empty_nxt   = 1'b0;
          p_found_nxt = 1'b0;
          n_found_nxt = 1'b0;
          placed_nxt  = 1'b0;
          avail_nxt   = '0;
          alloc_nxt   = '0;
          nfree_nxt   = '0;
          nused_nxt   = '0;
          cnt_nxt     = '0;
          state_nxt   = S_SCAN;
        end
      end

      // first lap: look only, the ring goes round unchanged
      S_SCAN: begin
        if (!tail.present) begin
          empty_nxt = 1'b1;
        end
        if (mode_r == MODE_ALLOC) begin
          if (fit && (!found_r || tail.start < hit_start_r)) begin
            found_nxt     = 1'b1;
            hit_start_nxt = tail.start;
            hit_len_nxt   = tail.len;
          end
        end else begin
          if (fs_ok_r && tail.present && tail.used && tail.start == fs_r) begin
            found_nxt   = 1'b1;
            hit_len_nxt = tail.len;
          end
          if (is_prev) begin
            p_found_nxt = 1'b1;
          end
          if (tail.present && tail.start > fs_r &&
              (!n_found_r || tail.start < n_start_r)) begin
            n_found_nxt = 1'b1;
            n_start_nxt = tail.start;
            n_len_nxt   = tail.len;
            n_free_nxt  = !tail.used;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_APPLY;
        end
      end

      // second lap: edit entries in passing and total up what leaves the head
      S_APPLY: begin
        if (mode_r == MODE_ALLOC) begin
          if (found_r && tail.present && !tail.used && tail.start == hit_start_r) begin
            head.used = 1'b1;
            if (split) begin
              head.len = need_r[OFF_W-1:0];
            end
          end else if (split && !placed_r && !tail.present) begin
            head       = rem;
            placed_nxt = 1'b1;
          end
        end else if (found_r) begin
          if (is_prev) begin
            head.len = tail.len + merged_len;
          end else if (tail.present && tail.used && tail.start == fs_r) begin
            if (p_found_r) begin
              head.present = 1'b0;
            end else begin
              head.used = 1'b0;
              head.len  = merged_len;
            end
          end else if (nmerge && tail.present && !tail.used && tail.start == n_start_r) begin
            head.present = 1'b0;
          end
        end
        if (head.present) begin
          if (head.used) begin
            alloc_nxt = alloc_r + head.len;
            nused_nxt = nused_r + 1'b1;
          end else begin
            avail_nxt = avail_r + head.len;
            nfree_nxt = nfree_r + 1'b1;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {nused_r, nfree_r, alloc_r, avail_r, grant, status};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    need_r      <= need_nxt;
    fs_r        <= fs_nxt;
    fs_ok_r     <= fs_ok_nxt;
    null_r      <= null_nxt;
    found_r     <= found_nxt;
    empty_r     <= empty_nxt;
    hit_start_r <= hit_start_nxt;
    hit_len_r   <= hit_len_nxt;
    p_found_r   <= p_found_nxt;
    n_found_r   <= n_found_nxt;
    n_free_r    <= n_free_nxt;
    n_start_r   <= n_start_nxt;
    n_len_r     <= n_len_nxt;
    placed_r    <= placed_nxt;
    avail_r     <= avail_nxt;
    alloc_r     <= alloc_nxt;
    nfree_r     <= nfree_nxt;
    nused_r     <= nused_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/first_fit_pool_allocator_core.sv]
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tuser: mode; tdata: request_bytes, block_address
// out_      out  out_tvalid/out_tready tdata: status, granted_address, bytes_available,
//                                      bytes_allocated, free_block_count, used_block_count
// cfg_      in   cfg_we               cfg_wdata: pool_bytes
//
// Each request rotates the ring of 64 block cells once to find the block, then once
// more to edit it and total the table, and then hands the beat to the output register.
// Reset and a pool write both leave one free block at offset 0 at once, no clearing lap.
// A waiting result does not hold the ring; a finished request waits only for the register.
module first_fit_pool_allocator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] request_bytes, [31:16] block_address
  input  logic [ffpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [17:2] granted_address, [33:18] bytes_available,
  // [49:34] bytes_allocated, [56:50] free_block_count, [63:57] used_block_count
  output logic [ffpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [ffpa_pkg::OFF_W-1:0]       cfg_wdata
);
  import ffpa_pkg::*;

  entry_t     chain [MAX_BLOCKS];
  entry_t     head;
  chain_ctl_t ctl;

  ffpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .tail       (chain[MAX_BLOCKS-1]),
    .head       (head),
    .ctl        (ctl)
  );

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    if (k == 0) begin : g_first
      ffpa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .is_first (1'b1),
        .d_in     (head),
        .q        (chain[k])
      );
    end else begin : g_rest
      ffpa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .is_first (1'b0),
        .d_in     (chain[k-1]),
        .q        (chain[k])
      );
    end
  end

endmodule

[hw/rtl/ffpa_checker.sv]
module ffpa_assertions (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ffpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ffpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_we,
  input logic [ffpa_pkg::OFF_W-1:0]       cfg_wdata
);
  import ffpa_pkg::*;

  localparam int GR_LO = 2;
  localparam int CF_LO = 2 + 3 * OFF_W;
  localparam int CU_LO = CF_LO + CNT_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while a request is in flight");

  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[GR_LO+OFF_W-1:GR_LO] == '0)
    else $error("failed request carries an address");

  a_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[CF_LO+CNT_W-1:CF_LO]} +
                    {1'b0, out_tdata[CU_LO+CNT_W-1:CU_LO]}) <= (CNT_W+1)'(MAX_BLOCKS))
    else $error("block counts exceed the table");

endmodule

bind first_fit_pool_allocator_core ffpa_assertions u_ffpa_assertions (.*);

[dv/ffpa_checker.sv]
`timescale 1ns / 100ps

module ffpa_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [ffpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ffpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [ffpa_pkg::OFF_W-1:0]       cfg_wdata,
  output int                               fail_count,
  output int                               pending
);
  import ffpa_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] used_cnt;
    logic [CNT_W-1:0] free_cnt;
    logic [OFF_W-1:0] allocated;
    logic [OFF_W-1:0] available;
    logic [OFF_W-1:0] grant;
    logic [1:0]       status;
  } alloc_result_t;

  int unsigned      tbl_start [MAX_BLOCKS];
  int unsigned      tbl_len   [MAX_BLOCKS];
  bit               tbl_used  [MAX_BLOCKS];
  bit               tbl_valid [MAX_BLOCKS];
  alloc_result_t    expected_q[$];

  assign pending = expected_q.size();

  function automatic void table_reset(logic [OFF_W-1:0] size);
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      tbl_start[k] = 0;
      tbl_len[k]   = 0;
      tbl_used[k]  = 0;
      tbl_valid[k] = 0;
    end
    tbl_valid[0] = 1;
    tbl_len[0]   = size;
  endfunction

  function automatic logic [1:0] alloc_block(int unsigned req,
                                             output logic [OFF_W-1:0] grant);
    int unsigned need;
    int          pick;
    int          slot;
    need = req;
    pick = -1;
    slot = -1;
    grant = '0;
    if (need % ALIGN_BYTES != 0)
      need += ALIGN_BYTES - need % ALIGN_BYTES;
    need += HDR_BYTES;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (!tbl_valid[k] || tbl_used[k] || tbl_len[k] < need)
        continue;
      if (pick < 0 || tbl_start[k] < tbl_start[pick])
        pick = k;
    end
    if (pick < 0)
      return ST_NOFIT;
    if (tbl_len[pick] >= need + HDR_BYTES) begin
      for (int k = MAX_BLOCKS - 1; k >= 0; k--)
        if (!tbl_valid[k])
          slot = k;
      // table full: grant the whole block
      if (slot >= 0) begin
        tbl_valid[slot] = 1;
        tbl_used[slot]  = 0;
        tbl_start[slot] = tbl_start[pick] + need;
        tbl_len[slot]   = tbl_len[pick] - need;
        tbl_len[pick]   = need;
      end
    end
    tbl_used[pick] = 1;
    grant = OFF_W'(tbl_start[pick] + HDR_BYTES);
    return ST_OK;
  endfunction

  function automatic logic [1:0] release_block(int unsigned addr);
    int cur;
    cur = -1;
    if (addr == 0)
      return ST_NULL;
    if (addr < HDR_BYTES)
      return ST_UNKNOWN;
    for (int k = 0; k < MAX_BLOCKS; k++)
      if (cur < 0 && tbl_valid[k] && tbl_used[k] && tbl_start[k] == addr - HDR_BYTES)
        cur = k;
    if (cur < 0)
      return ST_UNKNOWN;
    tbl_used[cur] = 0;
    // absorb the free neighbour above
    for (int k = 0; k < MAX_BLOCKS; k++)
      if (k != cur && tbl_valid[k] && !tbl_used[k] &&
          tbl_start[k] == tbl_start[cur] + tbl_len[cur]) begin
        tbl_len[cur] += tbl_len[k];
        tbl_valid[k] = 0;
        break;
      end
    // then fold into the free neighbour below
    for (int k = 0; k < MAX_BLOCKS; k++)
      if (k != cur && tbl_valid[k] && !tbl_used[k] &&
          tbl_start[k] + tbl_len[k] == tbl_start[cur]) begin
        tbl_len[k] += tbl_len[cur];
        tbl_valid[cur] = 0;
        break;
      end
    return ST_OK;
  endfunction

  function automatic alloc_result_t apply_request(logic mode, logic [OFF_W-1:0] req,
                                                  logic [OFF_W-1:0] addr);
    alloc_result_t r;
    int unsigned   avail;
    int unsigned   taken;
    int unsigned   nfree;
    int unsigned   nused;
    logic [OFF_W-1:0] g;
    avail = 0; taken = 0; nfree = 0; nused = 0;
    r = '0;
    g = '0;
    if (mode == MODE_ALLOC)
      r.status = alloc_block(req, g);
    else
      r.status = release_block(addr);
    r.grant = g;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (!tbl_valid[k])
        continue;
      if (tbl_used[k]) begin
        taken += tbl_len[k];
        nused++;
      end else begin
        avail += tbl_len[k];
        nfree++;
      end
    end
    r.available = OFF_W'(avail);
    r.allocated = OFF_W'(taken);
    r.free_cnt  = CNT_W'(nfree);
    r.used_cnt  = CNT_W'(nused);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    table_reset(POOL_RESET);
  end

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst_n) begin
      table_reset(POOL_RESET);
      expected_q.delete();
    end else begin
      if (cfg_we)
        table_reset(cfg_wdata);
      if (in_tvalid && in_tready)
        expected_q.push_back(apply_request(in_tuser, in_tdata[OFF_W-1:0],
                                           in_tdata[2*OFF_W-1:OFF_W]));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat %h", $realtime, got);
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status || got.grant != want.grant ||
              got.available != want.available || got.allocated != want.allocated ||
              got.free_cnt != want.free_cnt || got.used_cnt != want.used_cnt) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch exp st %0d grant %0d avail %0d used %0d nf %0d nu %0d",
                       $realtime, want.status, want.grant, want.available,
                       want.allocated, want.free_cnt, want.used_cnt);
              $display("%0t:          act st %0d grant %0d avail %0d used %0d nf %0d nu %0d",
                       $realtime, got.status, got.grant, got.available,
                       got.allocated, got.free_cnt, got.used_cnt);
            end
          end
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ffpa_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [OFF_W-1:0]       cfg_wdata;
  int                     fail_count;
  int                     pending;

  logic [OFF_W-1:0] grants[$];
  int               burst_left;
  int               accepted;
  int               long_hold;
  bit               hold_done;

  first_fit_pool_allocator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ffpa_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: short random stalls, quiet stretches, and one long hold-off
  initial begin
    out_tready = 1'b0;
    long_hold  = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted >= 300) begin
        hold_done = 1;
        long_hold = 2000;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if ((accepted / 64) % 3 == 1) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      accepted <= 0;
    else if (in_tvalid && in_tready)
      accepted <= accepted + 1;
    if (rst_n && out_tvalid && out_tready && out_tdata[1:0] == ST_OK &&
        out_tdata[17:2] != 0)
      grants.push_back(out_tdata[17:2]);
  end

  task automatic send(logic mode, logic [OFF_W-1:0] req, logic [OFF_W-1:0] addr);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 300)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {addr, req};
    do @(posedge clk); while (!in_tready);
  endtask

  // the scoreboard takes the last beat at the same edge, so wait for an edge before each look at pending
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_pool(logic [OFF_W-1:0] size);
    drain();
    repeat (140) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grants.delete();
  endtask

  task automatic random_requests(int count, int size_cap);
    int               pick;
    int               r;
    logic [OFF_W-1:0] req;
    logic [OFF_W-1:0] addr;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      req = OFF_W'($urandom_range(0, size_cap));
        else if (pick < 92) req = OFF_W'($urandom_range(0, 2000));
        else                req = OFF_W'($urandom());
        send(MODE_ALLOC, req, OFF_W'($urandom()));
      end else begin
        if (r < 92 && grants.size() != 0) begin
          pick = $urandom_range(0, grants.size() - 1);
          addr = grants[pick];
          grants.delete(pick);
        end else if (r < 95) begin
          addr = '0;
        end else begin
          addr = OFF_W'($urandom());
        end
        send(MODE_FREE, OFF_W'($urandom()), addr);
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = MODE_ALLOC;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed on the reset pool of 4096
    send(MODE_ALLOC, 16'd0, 16'd0);
    send(MODE_ALLOC, 16'd1, 16'd0);
    send(MODE_FREE, 16'd0, 16'd0);         // null
    send(MODE_FREE, 16'd0, 16'd8);         // below header
    send(MODE_FREE, 16'd0, 16'd16);
    send(MODE_FREE, 16'd0, 16'd16);        // already free
    send(MODE_ALLOC, 16'hFFFF, 16'hFFFF);  // oversized
    send(MODE_ALLOC, 16'd4000, 16'd0);
    send(MODE_FREE, 16'd0, 16'd48);        // unknown
    send(MODE_FREE, 16'd0, 16'd56);
    send(MODE_FREE, 16'd0, 16'd32);        // merges both sides
    send(MODE_ALLOC, 16'd4080, 16'd0);     // exact fit of the pool
    send(MODE_FREE, 16'd0, 16'd16);
    drain();                               // sender pause until all results in
    grants.delete();
    random_requests(200, 120);

    set_pool(16'hFFFF);
    random_requests(250, 64);              // small sizes fill the table

    set_pool(16'd16);
    send(MODE_ALLOC, 16'd1, 16'd0);
    send(MODE_ALLOC, 16'd0, 16'd0);
    send(MODE_FREE, 16'd0, 16'd16);
    send(MODE_ALLOC, 16'd0, 16'd0);

    set_pool(16'd0);
    send(MODE_ALLOC, 16'd0, 16'd0);
    send(MODE_FREE, 16'd0, 16'd16);

    set_pool(16'd300);
    random_requests(120, 40);

    set_pool(16'd4096);
    random_requests(160, 300);

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
